>>> src/srfr_pkg.sv
// Shared types, constants and the fade gain table for the slice renderer.
package srfr_pkg;

  localparam int SAMPLE_AW   = 16;
  localparam int CHAN_W      = 1;
  localparam int SLICE_AW    = 8;
  localparam int ORDER_AW    = 8;
  localparam int GAIN_BITS   = 10;
  localparam int GAIN_N      = 1 << GAIN_BITS;
  localparam int GAIN_HALF   = GAIN_N / 2;
  localparam int QUO_W       = GAIN_BITS + 1;
  localparam int FADE_W      = 16;
  localparam int DIVD_W      = FADE_W + GAIN_BITS + 1;
  localparam int SLICE_W     = 33;
  localparam logic [15:0] GAIN_UNITY = 16'h8000;

  localparam logic [1:0] CFG_CROSSFADE = 2'd0;
  localparam logic [1:0] CFG_ORDER_LEN = 2'd1;
  localparam logic [1:0] CFG_SLICE_CNT = 2'd2;
  localparam logic [1:0] CFG_CHAN_CNT  = 2'd3;

  typedef enum logic [2:0] {
    CMD_WR_SAMPLE = 3'd0,
    CMD_WR_SLICE  = 3'd1,
    CMD_WR_ORDER  = 3'd2,
    CMD_NEXT      = 3'd3,
    CMD_RESTART   = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               channel;
    logic [15:0]        index;
    logic signed [15:0] sample_in;
    logic [15:0]        slice_start;
    logic [16:0]        slice_length;
    logic [8:0]         slice_choice;
  } in_item_t;

  typedef struct packed {
    logic               out_channel;
    logic [23:0]        out_position;
    logic signed [15:0] sample_out;
    logic               done_res;
  } out_item_t;

  typedef logic [15:0] gain_tab_t [0:GAIN_N];

  // Shift-and-subtract quotient, used only while the gain table is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Raised-cosine gain 0.5(1-cos(pi*i/N)) in Q1.15 via a Taylor series in Q30.
  function automatic logic [15:0] gain_low(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint          acc;
    longint unsigned r;
    x = (64'd3373259426 * longint'(i) + GAIN_HALF) >> GAIN_BITS;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int k = 1; k <= 9; k++) begin
      d = longint'((2 * k - 1) * (2 * k));
      term = (udiv64(term * x2, d) + (64'd1 << 29)) >> 30;
      if (k[0] == 1'b1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    r = (longint'((64'sd1 << 30) - acc) + (64'd1 << 15)) >> 16;
    return r[15:0];
  endfunction

  function automatic gain_tab_t build_gain();
    gain_tab_t t;
    for (int i = 0; i <= GAIN_HALF; i++) t[i] = gain_low(i);
    for (int i = GAIN_HALF + 1; i <= GAIN_N; i++) t[i] = GAIN_UNITY - t[GAIN_N - i];
    return t;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain();

endpackage

>>> src/slice_reorder_fade_renderer.sv
// Top level of the slice renderer: command decode, render sequencer and output register.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries commands. Sample,
// slice and order writes and restart complete in the cycle of their transfer and
// give no result. A next command walks the order list, reads the order, slice and
// sample memories one after the other, and emits one result on the output channel
// (out_valid, out_stall, out_data): either a faded sample or a done marker.
// The time a next command takes is set by the chain of registered memory reads and
// by the serial divider that finds the gain table index, which runs only inside a
// fade; order entries with an out-of-range slice number and empty or finished slices
// are skipped on the way. While a next command is being worked on, in_stall is high.
// The result sits in an output register; a stalled receiver holds it there, and
// the block keeps taking writes meanwhile. A further result waits in the last
// sequencer step until that register is free. Synchronous reset clears the cursors
// and sets the registers to their defaults; the memory contents are undefined until
// written. Configuration must be written by the user through cfg_we, cfg_index and
// cfg_data only while no command is in flight; the block itself does not enforce this.
module slice_reorder_fade_renderer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srfr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import srfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ORD, S_ORDW, S_SLW, S_SMP, S_DIV, S_MUL, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] crossfade;
  logic [8:0]  order_len;
  logic [8:0]  slice_cnt;
  logic [1:0]  chan_cnt;

  // Render cursors.
  logic [8:0]  oc;
  logic [16:0] sc;
  logic        cc;
  logic [23:0] outc;

  // Per-frame working registers.
  logic [16:0]        slen;
  logic               fade_on;
  logic [15:0]        fnum;
  logic [15:0]        flen;
  logic signed [15:0] samp;
  logic [15:0]        gain;
  logic signed [32:0] prod;
  logic               emit_done;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Effective register values.
  logic [8:0] olen_eff;
  logic [8:0] scnt_eff;
  logic [1:0] nch;
  assign olen_eff = (order_len > 9'd256) ? 9'd256 : order_len;
  assign scnt_eff = (slice_cnt > 9'd256) ? 9'd256 : slice_cnt;
  always_comb begin
    if (chan_cnt == 2'd0) nch = 2'd1;
    else if (chan_cnt > 2'd2) nch = 2'd2;
    else nch = chan_cnt;
  end

  // Memories.
  logic [8:0]          ord_rd;
  logic [SLICE_W-1:0]  slc_rd;
  logic [15:0]         smp_rd;
  logic [SAMPLE_AW+CHAN_W-1:0] smp_raddr;

  logic cmd_smp, cmd_slc, cmd_ord;
  assign cmd_smp = accept && (in_data.cmd == CMD_WR_SAMPLE);
  assign cmd_slc = accept && (in_data.cmd == CMD_WR_SLICE) && (in_data.index[15:8] == 8'd0);
  assign cmd_ord = accept && (in_data.cmd == CMD_WR_ORDER) && (in_data.index[15:8] == 8'd0);

  srfr_ram #(.WIDTH(16), .DEPTH(1 << (SAMPLE_AW + CHAN_W))) u_smp (
    .clk(clk), .we(cmd_smp),
    .waddr({in_data.channel, in_data.index}),
    .wdata(in_data.sample_in),
    .raddr(smp_raddr), .rdata(smp_rd)
  );

  srfr_ram #(.WIDTH(SLICE_W), .DEPTH(1 << SLICE_AW)) u_slc (
    .clk(clk), .we(cmd_slc),
    .waddr(in_data.index[SLICE_AW-1:0]),
    .wdata({in_data.slice_start, in_data.slice_length}),
    .raddr(ord_rd[SLICE_AW-1:0]), .rdata(slc_rd)
  );

  srfr_ram #(.WIDTH(9), .DEPTH(1 << ORDER_AW)) u_ord (
    .clk(clk), .we(cmd_ord),
    .waddr(in_data.index[ORDER_AW-1:0]),
    .wdata(in_data.slice_choice),
    .raddr(oc[ORDER_AW-1:0]), .rdata(ord_rd)
  );

  // Slice step: close a frame left open by a channel count change, then look at
  // the slice end and the fade windows.
  logic [15:0] sl_start;
  logic [16:0] sl_len;
  logic        fix;
  logic [16:0] sc_a;
  logic [23:0] outc_a;
  logic        cc_a;
  logic [15:0] f_a;
  logic [16:0] tail_a;
  logic [16:0] rev_a;
  assign sl_start = slc_rd[SLICE_W-1:17];
  assign sl_len   = slc_rd[16:0];
  assign fix      = ({1'b0, cc} >= nch);
  assign sc_a     = fix ? sc + 17'd1 : sc;
  assign outc_a   = fix ? outc + 24'd1 : outc;
  assign cc_a     = fix ? 1'b0 : cc;
  assign f_a      = (sl_len[16:1] < crossfade) ? sl_len[16:1] : crossfade;
  assign tail_a   = sl_len - {1'b0, f_a};
  assign rev_a    = sl_len - 17'd1 - sc_a;
  assign smp_raddr = {cc_a, sl_start + sc_a[15:0]};

  // Divider for the gain index.
  logic             div_done;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] gidx;
  srfr_div u_div (
    .clk(clk), .rst(rst),
    .start(state == S_SMP && fade_on),
    .num(fnum), .den(flen),
    .done(div_done), .quo(quo)
  );
  assign gidx = (quo > QUO_W'(GAIN_N)) ? QUO_W'(GAIN_N) : quo;

  // Rounding and saturation of the product.
  logic signed [17:0] rnd;
  logic signed [15:0] sat;
  assign rnd = 18'((prod + 33'sd16384) >>> 15);
  always_comb begin
    if (rnd > 18'sd32767) sat = 16'sh7fff;
    else if (rnd < -18'sd32768) sat = 16'sh8000;
    else sat = rnd[15:0];
  end

  logic        out_free;
  logic [1:0]  cc_inc;
  logic [17:0] sc_inc;
  assign out_free = !out_valid || !out_stall;
  assign cc_inc   = {1'b0, cc} + 2'd1;
  assign sc_inc   = {1'b0, sc} + 18'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      crossfade <= '0;
      order_len <= '0;
      slice_cnt <= '0;
      chan_cnt  <= 2'd1;
      oc        <= '0;
      sc        <= '0;
      cc        <= 1'b0;
      outc      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CROSSFADE: crossfade <= cfg_data;
          CFG_ORDER_LEN: order_len <= cfg_data[8:0];
          CFG_SLICE_CNT: slice_cnt <= cfg_data[8:0];
          CFG_CHAN_CNT:  chan_cnt  <= cfg_data[1:0];
          default: ;
        endcase
      end
      // A new result takes the output register as the old one leaves it.
      if (state == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.cmd == CMD_RESTART) begin
              oc   <= '0;
              sc   <= '0;
              cc   <= 1'b0;
              outc <= '0;
            end else if (in_data.cmd == CMD_NEXT) begin
              state <= S_ORD;
            end
          end
        end
        S_ORD: begin
          if (oc >= olen_eff) begin
            emit_done <= 1'b1;
            state     <= S_EMIT;
          end else begin
            emit_done <= 1'b0;
            state     <= S_ORDW;
          end
        end
        S_ORDW: begin
          if (ord_rd >= scnt_eff) begin
            oc    <= oc + 9'd1;
            sc    <= '0;
            cc    <= 1'b0;
            state <= S_ORD;
          end else begin
            state <= S_SLW;
          end
        end
        S_SLW: begin
          outc <= outc_a;
          if (sc_a >= sl_len) begin
            oc    <= oc + 9'd1;
            sc    <= '0;
            cc    <= 1'b0;
            state <= S_ORD;
          end else begin
            sc    <= sc_a;
            cc    <= cc_a;
            slen  <= sl_len;
            flen  <= f_a;
            if (f_a == 16'd0) begin
              fade_on <= 1'b0;
            end else if (sc_a < {1'b0, f_a}) begin
              fade_on <= 1'b1;
              fnum    <= sc_a[15:0];
            end else if (sc_a >= tail_a) begin
              fade_on <= 1'b1;
              fnum    <= rev_a[15:0];
            end else begin
              fade_on <= 1'b0;
            end
            state <= S_SMP;
          end
        end
        S_SMP: begin
          samp <= smp_rd;
          if (fade_on) begin
            state <= S_DIV;
          end else begin
            gain  <= GAIN_UNITY;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain  <= GAIN_TAB[gidx];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= samp * $signed({1'b0, gain});
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (emit_done) begin
              out_data <= '{out_channel: 1'b0, out_position: '0,
                            sample_out: '0, done_res: 1'b1};
            end else begin
              out_data <= '{out_channel: cc, out_position: outc,
                            sample_out: sat, done_res: 1'b0};
              if (cc_inc >= nch) begin
                cc   <= 1'b0;
                outc <= outc + 24'd1;
                if (sc_inc >= {1'b0, slen}) begin
                  sc <= '0;
                  oc <= oc + 9'd1;
                end else begin
                  sc <= sc_inc[16:0];
                end
              end else begin
                cc <= cc_inc[0];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/srfr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module srfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/srfr_div.sv
// Restoring divider giving the rounded gain table index, one quotient bit per cycle.
module srfr_div
  import srfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FADE_W-1:0] num,
  input  logic [FADE_W-1:0] den,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);
  logic [DIVD_W-1:0]        rem;
  logic [DIVD_W-1:0]        dsh;
  logic [$clog2(QUO_W):0]   cnt;
  logic                     busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // Dividend is num*N + den/2; the quotient stays below 2N.
        rem  <= {1'b0, num, {GAIN_BITS{1'b0}}} + DIVD_W'(den >> 1);
        dsh  <= {1'b0, den, {GAIN_BITS{1'b0}}};
        cnt  <= '0;
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(QUO_W) + 1)'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sim/srfr_checker.sv
// Checker for the slice renderer: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module srfr_checker
  import srfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        pending
);

  logic signed [15:0] src_mem [0:1][0:65535];
  logic [15:0] seg_start [0:255];
  logic [16:0] seg_len [0:255];
  logic [8:0]  play_list [0:255];
  logic [15:0] fade_lut [0:1024];

  int unsigned list_pos, frame_pos, chan_pos;
  logic [23:0] write_pos;
  logic [15:0] fade_reg;
  logic [8:0]  list_len_reg, seg_cnt_reg;
  logic [1:0]  chan_cnt_reg;

  out_item_t due_q[$];
  int errors = 0;

  assign fail_count = errors;
  assign pending = due_q.size();

  // Raised-cosine entry for the lower half of the table, Q30 Taylor series.
  function automatic logic [15:0] lut_entry(int unsigned i);
    longint unsigned ang, ang2, t, div, r;
    longint sum;
    ang = (64'd3373259426 * i + 64'd512) / 64'd1024;
    ang2 = (ang * ang + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    sum = 64'sd1 << 30;
    for (int k = 1; k <= 9; k++) begin
      div = longint'((2 * k - 1) * (2 * k));
      t = (t * ang2 / div + (64'd1 << 29)) >> 30;
      if (k % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
    r = (longint'((64'sd1 << 30) - sum) + (64'd1 << 15)) >> 16;
    return r[15:0];
  endfunction

  function automatic int unsigned fade_gain_of(int unsigned num, int unsigned fl);
    longint unsigned idx;
    idx = ((longint'(num) << 10) + fl / 2) / fl;
    if (idx > 1024) idx = 1024;
    return fade_lut[idx];
  endfunction

  function automatic logic signed [15:0] scale(logic signed [15:0] s, int unsigned g);
    longint p, q;
    p = longint'(s) * longint'(g) + 16384;
    q = p >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // One next command: walk the play list and produce a faded sample or the done marker.
  function automatic out_item_t render_next();
    out_item_t r;
    int unsigned olen, scnt, nch, entry, len, fl, g, addr;
    r = '0;
    olen = (list_len_reg > 256) ? 256 : list_len_reg;
    scnt = (seg_cnt_reg > 256) ? 256 : seg_cnt_reg;
    nch = (chan_cnt_reg == 0) ? 1 : ((chan_cnt_reg > 2) ? 2 : chan_cnt_reg);
    forever begin
      if (list_pos >= olen) begin
        r.done_res = 1'b1;
        return r;
      end
      entry = play_list[list_pos];
      if (entry >= scnt) begin
        list_pos++; frame_pos = 0; chan_pos = 0;
        continue;
      end
      len = seg_len[entry];
      if (chan_pos >= nch) begin
        chan_pos = 0; frame_pos++; write_pos++;
      end
      if (frame_pos >= len) begin
        list_pos++; frame_pos = 0; chan_pos = 0;
        continue;
      end
      break;
    end
    fl = len / 2;
    if (fade_reg < fl) fl = fade_reg;
    g = 32768;
    if (fl > 0) begin
      if (frame_pos < fl) g = fade_gain_of(frame_pos, fl);
      else if (frame_pos >= len - fl) g = fade_gain_of(len - 1 - frame_pos, fl);
    end
    addr = (seg_start[entry] + frame_pos) % 65536;
    r.out_channel = chan_pos[0];
    r.out_position = write_pos;
    r.sample_out = scale(src_mem[chan_pos][addr], g);
    chan_pos++;
    if (chan_pos >= nch) begin
      chan_pos = 0; frame_pos++; write_pos++;
      if (frame_pos >= len) begin
        frame_pos = 0; list_pos++;
      end
    end
    return r;
  endfunction

  initial begin
    for (int i = 0; i <= 512; i++) fade_lut[i] = lut_entry(i);
    for (int i = 513; i <= 1024; i++) fade_lut[i] = 16'h8000 - fade_lut[1024 - i];
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      list_pos = 0; frame_pos = 0; chan_pos = 0; write_pos = '0;
      fade_reg = '0; list_len_reg = '0; seg_cnt_reg = '0; chan_cnt_reg = 2'd1;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CROSSFADE: fade_reg = cfg_data;
          CFG_ORDER_LEN: list_len_reg = cfg_data[8:0];
          CFG_SLICE_CNT: seg_cnt_reg = cfg_data[8:0];
          CFG_CHAN_CNT:  chan_cnt_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        end else begin
          want = due_q.pop_front();
          if (out_data.out_channel !== want.out_channel ||
              out_data.out_position !== want.out_position ||
              out_data.sample_out !== want.sample_out ||
              out_data.done_res !== want.done_res) begin
            errors++;
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.cmd)
          CMD_WR_SAMPLE: src_mem[in_data.channel][in_data.index] = in_data.sample_in;
          CMD_WR_SLICE: if (in_data.index < 256) begin
            seg_start[in_data.index] = in_data.slice_start;
            seg_len[in_data.index] = in_data.slice_length;
          end
          CMD_WR_ORDER: if (in_data.index < 256) play_list[in_data.index] = in_data.slice_choice;
          CMD_RESTART: begin
            list_pos = 0; frame_pos = 0; chan_pos = 0; write_pos = '0;
          end
          CMD_NEXT: due_q.push_back(render_next());
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sim/slice_reorder_fade_renderer_test.sv
// Testbench top for the slice renderer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module slice_reorder_fade_renderer_test;
  import srfr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 370;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count, pending;
  int cycles = 0;
  int fed = 0;
  bit calm = 0;       // Set for the last part of the run: no idling on either side.
  bit hold_req = 0;   // Asks the receiver for one long hold-off.
  bit hold_done = 0;

  // Slices and play-list positions that hold known content, so nothing undefined is read.
  bit seg_done [0:255];
  bit pos_done [0:255];
  int eff_slices = 0;

  always #6 clk = ~clk;

  slice_reorder_fade_renderer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  srfr_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // A hung block must not hang the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Every input field gets random content; the caller then sets the ones that matter.
  function automatic in_item_t noise();
    in_item_t it;
    it.cmd = 3'($urandom_range(0, 7));
    it.channel = 1'($urandom_range(0, 1));
    it.index = 16'($urandom);
    it.sample_in = 16'($urandom);
    it.slice_start = 16'($urandom);
    it.slice_length = 17'($urandom);
    it.slice_choice = 9'($urandom);
    return it;
  endfunction

  // Present one command and hold it until the block takes the transfer.
  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    fed++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic put_sample(logic ch, logic [15:0] addr, logic [15:0] v);
    in_item_t it;
    it = noise();
    it.cmd = CMD_WR_SAMPLE; it.channel = ch; it.index = addr; it.sample_in = v;
    send(it);
  endtask

  task automatic put_slice(logic [15:0] idx, logic [15:0] st, logic [16:0] ln);
    in_item_t it;
    it = noise();
    it.cmd = CMD_WR_SLICE; it.index = idx; it.slice_start = st; it.slice_length = ln;
    send(it);
    if (idx < 256) seg_done[idx] = 1;
  endtask

  // Slices stay inside the written sample window 65520..65535, 0..47 (wrapping).
  task automatic put_safe_slice(int idx);
    logic [15:0] st;
    logic [16:0] ln;
    st = $urandom_range(0, 1) ? 16'(65520 + $urandom_range(0, 15)) : 16'($urandom_range(0, 15));
    ln = ($urandom_range(0, 7) == 0) ? 17'd0 : 17'($urandom_range(1, 32));
    put_slice(16'(idx), st, ln);
  endtask

  task automatic put_order(logic [15:0] pos, logic [8:0] choice);
    in_item_t it;
    it = noise();
    it.cmd = CMD_WR_ORDER; it.index = pos; it.slice_choice = choice;
    send(it);
    if (pos < 256) pos_done[pos] = 1;
  endtask

  function automatic logic [8:0] pick_choice();
    if (eff_slices == 0 || $urandom_range(0, 4) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, eff_slices - 1));
  endfunction

  task automatic issue(cmd_t c);
    in_item_t it;
    it = noise();
    it.cmd = c;
    send(it);
  endtask

  // Drain the block before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write all four registers back to back, then make sure every slice and list
  // position the new setting can reach holds known content.
  task automatic setup(int fade, int olen, int scnt, int nch);
    int eo;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_CROSSFADE; cfg_data <= 16'(fade);
    @(posedge clk);
    cfg_index <= CFG_ORDER_LEN; cfg_data <= 16'(olen);
    @(posedge clk);
    cfg_index <= CFG_SLICE_CNT; cfg_data <= 16'(scnt);
    @(posedge clk);
    cfg_index <= CFG_CHAN_CNT; cfg_data <= 16'(nch);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_slices = (scnt > 256) ? 256 : scnt;
    eo = (olen > 256) ? 256 : olen;
    for (int i = 0; i < eff_slices; i++) if (!seg_done[i]) put_safe_slice(i);
    for (int i = 0; i < eo; i++) if (!pos_done[i]) put_order(16'(i), pick_choice());
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none once calm.
  initial begin
    wait (!rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int r, mark;
    in_item_t it;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the sample window on both channels; the first words carry the extremes.
    for (int ch = 0; ch < 2; ch++) begin
      for (int a = 0; a < 64; a++) begin
        case (a)
          16: put_sample(ch[0], 16'd0, 16'h8000);
          17: put_sample(ch[0], 16'd1, 16'h7fff);
          18: put_sample(ch[0], 16'd2, 16'h0000);
          19: put_sample(ch[0], 16'd3, 16'hffff);
          default: put_sample(ch[0], 16'(a - 16), 16'($urandom));
        endcase
      end
    end

    // Directed part. Out of reset the play list is empty, so a next gives the done marker.
    issue(CMD_NEXT);
    // Commands 5 to 7 are unused and do nothing.
    for (int c = 5; c < 8; c++) begin
      it = noise();
      it.cmd = 3'(c);
      send(it);
    end
    // Writes beyond the slice table and the play list are ignored.
    put_slice(16'd256, 16'hffff, 17'd65536);
    put_slice(16'hffff, 16'h0000, 17'd0);
    put_order(16'd300, 9'd0);
    put_order(16'hffff, 9'h1ff);

    // The longest slice with the widest fade, two channels; only its head is played.
    put_slice(16'd0, 16'd0, 17'd65536);
    put_order(16'd0, 9'd0);
    setup(65535, 1, 1, 2);
    issue(CMD_RESTART);
    repeat (8) issue(CMD_NEXT);

    // An out-of-range slice number and an empty slice are skipped; the last slice
    // wraps around the end of the sample store.
    put_slice(16'd1, 16'd65530, 17'd20);
    put_slice(16'd2, 16'd5, 17'd0);
    put_order(16'd0, 9'd5);
    put_order(16'd1, 9'd2);
    put_order(16'd2, 9'd1);
    setup(4, 3, 3, 1);
    issue(CMD_RESTART);
    repeat (22) issue(CMD_NEXT);
    put_safe_slice(0);

    // Random part: phases of settings, with extremes mixed in; a phase starts without
    // a restart now and then, so a render carries over a change of settings.
    mark = fed;
    while (fed - mark < RANDOM_ITEMS) begin
      if (fed - mark > RANDOM_ITEMS * 85 / 100) calm = 1;
      if (fed - mark > 150) hold_req = 1;
      r = $urandom_range(0, 9);
      setup((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 65535 : $urandom_range(0, 20),
            (r == 3) ? 0 : (r == 4) ? 256 : (r == 5) ? 511 : $urandom_range(1, 12),
            (r == 6) ? 0 : (r == 7) ? 256 : (r == 8) ? 300 : $urandom_range(1, 12),
            $urandom_range(0, 3));
      if ($urandom_range(0, 3) != 0) issue(CMD_RESTART);
      repeat ($urandom_range(20, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 50) issue(CMD_NEXT);
        else if (r < 64) begin
          if ($urandom_range(0, 3) == 0) put_sample(1'($urandom), 16'($urandom), 16'($urandom));
          else put_sample(1'($urandom), 16'($urandom_range(0, 63) - 16), 16'($urandom));
        end else if (r < 76) begin
          if ($urandom_range(0, 4) == 0)
            put_slice(16'($urandom_range(256, 65535)), 16'($urandom), 17'($urandom));
          else put_safe_slice($urandom_range(0, 255));
        end else if (r < 88) begin
          if ($urandom_range(0, 4) == 0) put_order(16'($urandom_range(256, 65535)), 9'($urandom));
          else put_order(16'($urandom_range(0, 255)), pick_choice());
        end else if (r < 94) issue(CMD_RESTART);
        else begin
          it = noise();
          it.cmd = 3'($urandom_range(5, 7));
          send(it);
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
src/srfr_pkg.sv
src/srfr_ram.sv
src/srfr_div.sv
src/slice_reorder_fade_renderer.sv
sim/srfr_checker.sv
sim/slice_reorder_fade_renderer_test.sv
